### rtl/core/pcmr_pkg.sv
// ----------------------------------------------------------------------------
// pcmr_pkg: shared types and codes for the PCM ring resampler
// Function, status and register index codes, the gain limit, configuration bundles and the queue item.
// ----------------------------------------------------------------------------
package pcmr_pkg;

  localparam logic [1:0] FUNC_PUSH      = 2'd0;
  localparam logic [1:0] FUNC_PULL      = 2'd1;
  localparam logic [1:0] FUNC_CLR_RING  = 2'd2;
  localparam logic [1:0] FUNC_CLR_UNDER = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_UNDER = 2'd2;
  localparam logic [1:0] STAT_IDLE  = 2'd3;

  localparam logic [2:0] REG_PLAYING      = 3'd0;
  localparam logic [2:0] REG_GAIN         = 3'd1;
  localparam logic [2:0] REG_PHASE_STEP   = 3'd2;
  localparam logic [2:0] REG_SAMPLE_BYTES = 3'd3;
  localparam logic [2:0] REG_CHANNELS     = 3'd4;
  localparam logic [2:0] REG_FLOAT_FORMAT = 3'd5;

  localparam logic [15:0] GAIN_MAX = 16'd32768;

  typedef struct packed {
    logic [2:0] sample_bytes;
    logic [1:0] channels;
    logic       float_format;
  } front_cfg_t;

  typedef struct packed {
    logic        playing;
    logic [15:0] gain;
    logic [34:0] phase_step;
  } back_cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] sample;
  } q_item_t;

endpackage

### rtl/core/pcmr_front.sv
// ----------------------------------------------------------------------------
// pcmr_front: input stage and frame converter
// Holds one accepted item and turns a raw frame into a clamped mono int16.
// ----------------------------------------------------------------------------
module pcmr_front import pcmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // func
  input  logic [63:0] in_tdata,   // frame_bytes
  input  front_cfg_t  cfg,
  output logic        q_valid,
  output q_item_t     q_item,
  input  logic        q_ready
);

  logic        hold_valid_r;
  logic [1:0]  hold_func_r;
  logic [63:0] hold_frame_r;

  logic [31:0]        ch1_word;
  logic signed [31:0] ch0_val, ch1_val;
  logic signed [32:0] sum, acc;
  logic [15:0]        mono;

  function automatic logic signed [31:0] to_chan(input logic [31:0] w,
                                                 input logic is_float,
                                                 input logic [2:0] sb);
    logic [7:0]         e;
    logic [23:0]        m;
    logic [38:0]        mm;
    logic [38:0]        shd;
    logic [7:0]         rsh;
    logic [30:0]        mag;
    logic signed [31:0] r;
    e   = w[30:23];
    m   = {(e != 8'd0), w[22:0]};
    mm  = {m, 15'b0} - {15'b0, m};
    rsh = (e == 8'd0) ? 8'd149 : 8'd150 - e;
    shd = mm >> rsh[5:0];
    if (e == 8'hFF) begin
      mag = (w[22:0] != 23'd0) ? 31'd0 : {31{1'b1}};
    end else if (e >= 8'd150) begin
      mag = {31{1'b1}};
    end else if (rsh >= 8'd39) begin
      mag = 31'd0;
    end else if (shd[38:31] != 8'd0) begin
      mag = {31{1'b1}};
    end else begin
      mag = shd[30:0];
    end
    if (is_float) begin
      r = w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end else begin
      case (sb)
        3'd1:    r = $signed({{16{~w[7]}}, ~w[7], w[6:0], 8'b0});
        3'd3:    r = $signed({{16{w[23]}}, w[23:8]});
        3'd4:    r = $signed({{16{w[31]}}, w[31:16]});
        default: r = $signed({{16{w[15]}}, w[15:0]});
      endcase
    end
    return r;
  endfunction

  assign in_tready = !hold_valid_r || q_ready;
  assign q_valid   = hold_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_tready) begin
      hold_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_func_r  <= in_tuser;
      hold_frame_r <= in_tdata;
    end
  end

  // second channel sits one stride up; float frames always use four bytes
  always_comb begin
    if (cfg.float_format) begin
      ch1_word = hold_frame_r[63:32];
    end else begin
      case (cfg.sample_bytes)
        3'd1:    ch1_word = hold_frame_r[39:8];
        3'd3:    ch1_word = hold_frame_r[55:24];
        3'd4:    ch1_word = hold_frame_r[63:32];
        default: ch1_word = hold_frame_r[47:16];
      endcase
    end
  end

  always_comb begin
    ch0_val = to_chan(hold_frame_r[31:0], cfg.float_format, cfg.sample_bytes);
    ch1_val = to_chan(ch1_word, cfg.float_format, cfg.sample_bytes);
    sum     = {ch0_val[31], ch0_val} + {ch1_val[31], ch1_val};
    // average, truncating toward zero
    if (cfg.channels == 2'd2) begin
      acc = $signed(sum + {32'd0, sum[32]}) >>> 1;
    end else begin
      acc = {ch0_val[31], ch0_val};
    end
    if (acc < -33'sd32768) begin
      mono = 16'h8000;
    end else if (acc > 33'sd32767) begin
      mono = 16'h7FFF;
    end else begin
      mono = acc[15:0];
    end
  end

  assign q_item.func   = hold_func_r;
  assign q_item.sample = mono;

endmodule

### rtl/core/pcmr_queue.sv
// ----------------------------------------------------------------------------
// pcmr_queue: two-entry queue between front and back
// Decouples conversion from ring access so each side stalls on its own.
// ----------------------------------------------------------------------------
module pcmr_queue import pcmr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  q_item_t wr_item,
  output logic    rd_valid,
  input  logic    rd_ready,
  output q_item_t rd_item
);

  q_item_t    ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = ent_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wr_item;
  end

endmodule

### rtl/core/pcmr_back.sv
// ----------------------------------------------------------------------------
// pcmr_back: ring, phase accumulator and interpolator
// Executes queued items against the sample ring and drives the result stage.
// ----------------------------------------------------------------------------
module pcmr_back import pcmr_pkg::*; #(
  parameter int RING_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  q_item_t     q_item,
  input  back_cfg_t   cfg,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDB  = 2'd1;
  localparam logic [1:0] S_MUL1 = 2'd2;
  localparam logic [1:0] S_MUL2 = 2'd3;

  logic [15:0] mem [RING_DEPTH];
  logic [15:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] wc_r, wc_nxt, rc_r, rc_nxt, fill, fill_nxt;
  logic [31:0]   pf_r, pf_nxt, und_r, und_nxt;
  logic signed [15:0] a_r;
  logic signed [33:0] prod_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_stat_r, out_stat_nxt;
  logic [16:0] out_samp_r, out_samp_nxt;
  logic [12:0] out_fill_r;
  logic [31:0] out_und_r;

  logic        can_emit, emit, take;
  logic [15:0] g_eff;
  logic [35:0] ph;
  logic [3:0]  consumed;
  logic        underrun;
  logic signed [16:0] diff;
  logic signed [33:0] v;
  logic signed [50:0] scaled;

  assign can_emit = !out_valid_r || out_tready;
  assign q_ready  = (state_r == S_IDLE) && can_emit;
  assign take     = q_valid && q_ready;
  assign fill     = wc_r - rc_r;
  assign g_eff    = (cfg.gain > GAIN_MAX) ? GAIN_MAX : cfg.gain;
  assign ph       = {4'd0, pf_r} + {1'b0, cfg.phase_step};
  assign consumed = ph[35:32];
  assign underrun = {1'b0, fill} < ((CW + 1)'(consumed) + (CW + 1)'(2));
  assign rd_addr  = (state_r == S_IDLE) ? rc_r[AW-1:0] : rc_r[AW-1:0] + AW'(1);
  assign diff     = $signed({rd_data_r[15], rd_data_r}) - $signed({a_r[15], a_r});
  assign v        = ($signed({{18{a_r[15]}}, a_r}) <<< 16) + prod_r;
  assign scaled   = v * $signed({1'b0, g_eff});

  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    rc_nxt        = rc_r;
    pf_nxt        = pf_r;
    und_nxt       = und_r;
    mem_we        = 1'b0;
    emit          = 1'b0;
    out_stat_nxt  = STAT_OK;
    out_samp_nxt  = 17'd0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (q_item.func)
            FUNC_PUSH: begin
              emit = 1'b1;
              if (fill[CW-1]) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                wc_nxt = wc_r + CW'(1);
              end
            end
            FUNC_PULL: begin
              if (!cfg.playing || g_eff == 16'd0) begin
                emit         = 1'b1;
                out_stat_nxt = STAT_IDLE;
              end else if (underrun) begin
                emit         = 1'b1;
                out_stat_nxt = STAT_UNDER;
                if (und_r != 32'hFFFF_FFFF) und_nxt = und_r + 32'd1;
              end else begin
                state_nxt = S_RDB;
              end
            end
            FUNC_CLR_RING: begin
              emit   = 1'b1;
              wc_nxt = '0;
              rc_nxt = '0;
              pf_nxt = 32'd0;
            end
            default: begin
              emit    = 1'b1;
              und_nxt = 32'd0;
            end
          endcase
        end
      end
      S_RDB:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      default: begin
        if (can_emit) begin
          emit         = 1'b1;
          out_samp_nxt = scaled[46:30];
          rc_nxt       = rc_r + CW'(consumed);
          pf_nxt       = ph[31:0];
          state_nxt    = S_IDLE;
        end
      end
    endcase
    fill_nxt      = wc_nxt - rc_nxt;
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wc_r[AW-1:0]] <= q_item.sample;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wc_r        <= '0;
      rc_r        <= '0;
      pf_r        <= 32'd0;
      und_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      rc_r        <= rc_nxt;
      pf_r        <= pf_nxt;
      und_r       <= und_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDB)  a_r    <= $signed(rd_data_r);
    if (state_r == S_MUL1) prod_r <= diff * $signed({1'b0, pf_r[31:16]});
    if (emit) begin
      out_stat_r <= out_stat_nxt;
      out_samp_r <= out_samp_nxt;
      out_fill_r <= 13'(fill_nxt);
      out_und_r  <= und_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {2'b00, out_und_r, out_fill_r, out_samp_r};

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= CW'(RING_DEPTH))
    else $error("ring fill exceeds depth");

  a_mul2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL2 && !can_emit) |=> (state_r == S_MUL2))
    else $error("interpolator left before result stage was free");

  a_clear_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_item.func == FUNC_CLR_RING) |=> (out_fill_r == 13'd0))
    else $error("clear ring did not report empty");

  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != STAT_OK) |-> (out_samp_r == 17'd0))
    else $error("refused item carries a sample");

endmodule

### rtl/core/pcm_ring_linear_resampler.sv
// ----------------------------------------------------------------------------
// pcm_ring_linear_resampler: PCM ring with linear-interpolating rate converter
// Converts pushed frames to mono int16, stores them in a ring and returns
// gain-scaled interpolated samples on pulls.
// ----------------------------------------------------------------------------
// Path: push, clear and refused pulls pass the front hold, queue and result
//   registers; an interpolated pull adds ring read a, read b, multiply, scale.
// Throughput: one push or clear per cycle unless output stalls; an interpolated
//   pull holds the back end for its single-port ring reads and two multiplies.
// Reset: rst_n is synchronous, active low; counters, phase, underrun count and
//   config return to defaults. Ring contents are not cleared (no clearing pass).
module pcm_ring_linear_resampler import pcmr_pkg::*; #(
  parameter int RING_DEPTH = 4096  // power of two
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // [1:0] func
  input  logic [63:0] in_tdata,    // [63:0] frame_bytes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,   // [1:0] status
  output logic [63:0] out_tdata,   // [16:0] sample_out, [29:17] fill_level,
                                   // [61:30] underrun_count, zero pad above
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [34:0] cfg_data
);

  front_cfg_t fcfg_r;
  back_cfg_t  bcfg_r;

  logic    f_valid, f_ready, b_valid, b_ready;
  q_item_t f_item, b_item;

  // config registers; the user must write them only while the block is idle; no idle check is made
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcfg_r.playing      <= 1'b0;
      bcfg_r.gain         <= 16'd13107;
      bcfg_r.phase_step   <= 35'h1_0000_0000;
      fcfg_r.sample_bytes <= 3'd2;
      fcfg_r.channels     <= 2'd1;
      fcfg_r.float_format <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PLAYING:      bcfg_r.playing      <= cfg_data[0];
        REG_GAIN:         bcfg_r.gain         <= cfg_data[15:0];
        REG_PHASE_STEP:   bcfg_r.phase_step   <= cfg_data;
        REG_SAMPLE_BYTES: fcfg_r.sample_bytes <= cfg_data[2:0];
        REG_CHANNELS:     fcfg_r.channels     <= cfg_data[1:0];
        REG_FLOAT_FORMAT: fcfg_r.float_format <= cfg_data[0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // front: hold and convert
  pcmr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg       (fcfg_r),
    .q_valid   (f_valid),
    .q_item    (f_item),
    .q_ready   (f_ready)
  );

  // queue between front and back
  pcmr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  // back: ring, phase and interpolation
  pcmr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_item     (b_item),
    .cfg        (bcfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
